// ----- rtl/cslf_pkg.sv -----
// cslf_pkg: shared types and constants for the cache set with LRU/FIFO replacement.
// No dependencies.
`timescale 1ns / 1ps

package cslf_pkg;

    localparam int TAG_W  = 32;
    localparam int TIME_W = 64;
    localparam int AGE_W  = 32;

    localparam logic [1:0] REQ_LOOKUP  = 2'd0;
    localparam logic [1:0] REQ_PROBE   = 2'd1;
    localparam logic [1:0] REQ_FILL    = 2'd2;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    localparam logic POL_LRU  = 1'b0;
    localparam logic POL_FIFO = 1'b1;

    localparam logic CFG_WAYS_IN_USE = 1'b0;
    localparam logic CFG_POLICY      = 1'b1;

    localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

    // one result transfer, hit in the lowest bit
    typedef struct packed {
        logic       set_full;
        logic [2:0] fill_way;
        logic       evicted;
        logic [2:0] hit_way;
        logic       hit;
    } result_t;

endpackage

// ----- rtl/cache_set_lru_fifo.sv -----
// cache_set_lru_fifo: cache set with LRU/FIFO replacement, shared compare unit; uses cslf_pkg.
// Flow: a request is accepted in idle, its occupied ways are read in turn, one way read
//   per cycle with each read registered before the compare, and the result is written back;
//   unscanned requests (LRU fill of a free way, empty set, unknown request) skip the reads.
//   One request at a time: none is accepted before write-back; a held result stalls write-back.
// Reset: async active low; clears occupancy, loads ways_in_use = 8 and LRU, no memory clear.
`timescale 1ns / 1ps

module cache_set_lru_fifo
    import cslf_pkg::*;
#(
    parameter int MAX_WAYS = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [3:0]   cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // tag[31:0], access_time[95:32]
    input  logic [1:0]   s_axis_tuser,   // req_type[1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [15:0]  m_axis_tdata    // hit, hit_way[3:1], evicted, fill_way[7:5], set_full
);

    localparam int OCCW = $clog2(MAX_WAYS + 1);
    localparam int IDXW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int CW   = (OCCW > 4) ? OCCW : 4;
    localparam logic [CW-1:0] MAXW = CW'(MAX_WAYS);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;

    logic [TAG_W-1:0]  tag_mem   [MAX_WAYS];
    logic [TIME_W-1:0] stamp_mem [MAX_WAYS];
    logic [AGE_W-1:0]  age_mem   [MAX_WAYS];

    logic [1:0]        state_reg, state_next;
    logic [3:0]        ways_reg;
    logic              policy_reg;
    logic [OCCW-1:0]   occ_reg;
    logic [1:0]        req_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [TIME_W-1:0] time_reg;
    logic              full_reg;
    logic [OCCW-1:0]   idx_reg;
    logic              dv_reg;
    logic [IDXW-1:0]   didx_reg;
    logic [TAG_W-1:0]  rd_tag_reg;
    logic [TIME_W-1:0] rd_stamp_reg;
    logic [AGE_W-1:0]  rd_age_reg;
    logic              found_reg;
    logic [IDXW-1:0]   found_way_reg;
    logic [TIME_W-1:0] best_key_reg;
    logic [IDXW-1:0]   best_way_reg;
    logic              out_valid_reg;
    result_t           result_reg;

    logic [CW-1:0]     eff_ways;
    logic              in_xfer;
    logic              out_free;
    logic              rd_en;
    logic              last_data;
    logic              is_fill;
    logic [AGE_W-1:0]  aged;
    logic [TIME_W-1:0] key_cur;
    logic              key_less;
    logic              do_write;
    logic [IDXW-1:0]   pick;
    logic [OCCW-1:0]   occ_after;
    logic              skip_scan;
    logic [1:0]        in_req;
    logic              in_full;

    logic              tag_we;
    logic              stamp_we;
    logic [IDXW-1:0]   stamp_addr;
    logic              age_we;
    logic [IDXW-1:0]   age_addr;
    logic [AGE_W-1:0]  age_wdata;

    always_comb
    begin
        if (ways_reg == 4'd0)
        begin
            eff_ways = CW'(1);
        end
        else if (CW'(ways_reg) > MAXW)
        begin
            eff_ways = MAXW;
        end
        else
        begin
            eff_ways = CW'(ways_reg);
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign in_req        = s_axis_tuser;
    assign in_full       = CW'(occ_reg) >= eff_ways;
    assign skip_scan     = (occ_reg == OCCW'(0)) || (in_req == REQ_UNKNOWN)
                        || ((in_req == REQ_FILL) && !in_full && (policy_reg == POL_LRU));

    assign is_fill   = (req_reg == REQ_FILL);
    assign rd_en     = (state_reg == S_SCAN) && (idx_reg < occ_reg);
    assign last_data = dv_reg && ((OCCW'(didx_reg) + OCCW'(1)) == occ_reg);

    // shared compare unit: minimum stamp for LRU, maximum aged load age for FIFO
    assign aged     = (rd_age_reg == AGE_MAX) ? rd_age_reg : rd_age_reg + AGE_W'(1);
    assign key_cur  = (policy_reg == POL_FIFO) ? {{(TIME_W-AGE_W){1'b1}}, ~aged}
                                               : rd_stamp_reg;
    assign key_less = key_cur < best_key_reg;

    assign do_write  = (state_reg == S_WRITE) && out_free;
    assign pick      = full_reg ? best_way_reg : occ_reg[IDXW-1:0];
    assign occ_after = (is_fill && !full_reg) ? occ_reg + OCCW'(1) : occ_reg;

    assign tag_we     = do_write && is_fill;
    assign stamp_we   = do_write && (is_fill || ((req_reg == REQ_LOOKUP) && found_reg));
    assign stamp_addr = is_fill ? pick : found_way_reg;
    assign age_we     = (do_write && is_fill)
                     || (dv_reg && is_fill && (policy_reg == POL_FIFO));
    assign age_addr   = (state_reg == S_WRITE) ? pick : didx_reg;
    assign age_wdata  = (state_reg == S_WRITE) ? AGE_W'(0) : aged;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = skip_scan ? S_WRITE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (last_data)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ways_reg      <= 4'd8;
            policy_reg    <= POL_LRU;
            occ_reg       <= '0;
            idx_reg       <= '0;
            dv_reg        <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                if (cfg_index == CFG_WAYS_IN_USE)
                begin
                    ways_reg <= cfg_wdata;
                end
                else
                begin
                    policy_reg <= cfg_wdata[0];
                end
            end
            if (in_xfer)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            else if (rd_en)
            begin
                idx_reg <= idx_reg + OCCW'(1);
            end
            dv_reg <= rd_en;
            if (dv_reg && !found_reg && (rd_tag_reg == tag_reg))
            begin
                found_reg <= 1'b1;
            end
            if (do_write)
            begin
                occ_reg       <= occ_after;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            req_reg  <= in_req;
            tag_reg  <= s_axis_tdata[31:0];
            time_reg <= s_axis_tdata[95:32];
            full_reg <= in_full;
        end
        if (rd_en)
        begin
            didx_reg     <= idx_reg[IDXW-1:0];
            rd_tag_reg   <= tag_mem[idx_reg[IDXW-1:0]];
            rd_stamp_reg <= stamp_mem[idx_reg[IDXW-1:0]];
            rd_age_reg   <= age_mem[idx_reg[IDXW-1:0]];
        end
        if (dv_reg && !found_reg && (rd_tag_reg == tag_reg))
        begin
            found_way_reg <= didx_reg;
        end
        if (dv_reg && ((didx_reg == IDXW'(0)) || key_less))
        begin
            best_key_reg <= key_cur;
            best_way_reg <= didx_reg;
        end
        if (do_write)
        begin
            result_reg.hit      <= (req_reg == REQ_LOOKUP || req_reg == REQ_PROBE)
                                   && found_reg;
            result_reg.hit_way  <= ((req_reg == REQ_LOOKUP || req_reg == REQ_PROBE)
                                   && found_reg) ? 3'(found_way_reg) : 3'd0;
            result_reg.evicted  <= is_fill && full_reg;
            result_reg.fill_way <= is_fill ? 3'(pick) : 3'd0;
            result_reg.set_full <= CW'(occ_after) >= eff_ways;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[pick] <= tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stamp_we)
        begin
            stamp_mem[stamp_addr] <= time_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (age_we)
        begin
            age_mem[age_addr] <= age_wdata;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, result_reg};

`ifndef SYNTHESIS
    a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg != $past(occ_reg)) |-> (occ_reg == $past(occ_reg) + OCCW'(1)))
        else $error("occupancy changed by other than one");

    a_result_from_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> ($past(state_reg) == S_WRITE))
        else $error("result appeared outside write-back");

    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[4]) |-> m_axis_tdata[8])
        else $error("eviction reported on a set that is not full");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dv_reg |-> (OCCW'(didx_reg) < occ_reg))
        else $error("scan read beyond occupied ways");
`endif

endmodule
